>>> hw/rtl/vclp_pkg.sv
// Package for the voxel code lookup block: codes, constants and the
// command, status and configuration structs shared by its modules.
// Depends on nothing.
`default_nettype none
package vclp_pkg;

	localparam logic [15:0] NO_DATA_CODE = 16'hD8F1; // -9999
	localparam logic [31:0] NO_DATA_32   = 32'hFFFF_D8F1;

	localparam logic [1:0] STATUS_FOUND   = 2'd0;
	localparam logic [1:0] STATUS_NO_ELEV = 2'd1;
	localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [2:0] REG_X_ORIGIN    = 3'd0;
	localparam logic [2:0] REG_Y_ORIGIN    = 3'd1;
	localparam logic [2:0] REG_Z_ORIGIN    = 3'd2;
	localparam logic [2:0] REG_CELL_SIZE   = 3'd3;
	localparam logic [2:0] REG_LAYER_THICK = 3'd4;
	localparam logic [2:0] REG_ROW_COUNT   = 3'd5;
	localparam logic [2:0] REG_COL_COUNT   = 3'd6;
	localparam logic [2:0] REG_LAYER_COUNT = 3'd7;

	// magnitudes are 33 bits, one quotient bit per step
	localparam int DIV_BITS = 33;
	localparam logic [5:0] DIV_LAST = 6'(DIV_BITS - 1);

	typedef struct packed {
		logic signed [31:0] x_origin;
		logic signed [31:0] y_origin;
		logic signed [31:0] z_origin;
		logic [19:0]        cell_size;
		logic [19:0]        layer_thickness;
		logic [6:0]         row_count;
		logic [6:0]         col_count;
		logic [5:0]         layer_count;
	} cfg_t;

	typedef struct packed {
		logic clear_wr;
		logic load_wr;
		logic capture;
		logic div_load;
		logic div_step;
		logic lookup;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
	} stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/vclp_regs.sv
// Configuration register file behind an APB-style port.
// Depends on vclp_pkg.
`default_nettype none
module vclp_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [4:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic      [31:0]   prdata,
	output logic               pready,
	output vclp_pkg::cfg_t     cfg
);
	import vclp_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// write one register per completed access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_origin        <= '0;
			cfg_q.y_origin        <= '0;
			cfg_q.z_origin        <= '0;
			cfg_q.cell_size       <= 20'd160;
			cfg_q.layer_thickness <= 20'd160;
			cfg_q.row_count       <= 7'd64;
			cfg_q.col_count       <= 7'd64;
			cfg_q.layer_count     <= 6'd32;
		end else if (wr_en) begin
			case (idx)
				REG_X_ORIGIN:    cfg_q.x_origin        <= pwdata;
				REG_Y_ORIGIN:    cfg_q.y_origin        <= pwdata;
				REG_Z_ORIGIN:    cfg_q.z_origin        <= pwdata;
				REG_CELL_SIZE:   cfg_q.cell_size       <= pwdata[19:0];
				REG_LAYER_THICK: cfg_q.layer_thickness <= pwdata[19:0];
				REG_ROW_COUNT:   cfg_q.row_count       <= pwdata[6:0];
				REG_COL_COUNT:   cfg_q.col_count       <= pwdata[6:0];
				REG_LAYER_COUNT: cfg_q.layer_count     <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_X_ORIGIN:    prdata = cfg_q.x_origin;
			REG_Y_ORIGIN:    prdata = cfg_q.y_origin;
			REG_Z_ORIGIN:    prdata = cfg_q.z_origin;
			REG_CELL_SIZE:   prdata = {12'd0, cfg_q.cell_size};
			REG_LAYER_THICK: prdata = {12'd0, cfg_q.layer_thickness};
			REG_ROW_COUNT:   prdata = {25'd0, cfg_q.row_count};
			REG_COL_COUNT:   prdata = {25'd0, cfg_q.col_count};
			REG_LAYER_COUNT: prdata = {26'd0, cfg_q.layer_count};
			default:         prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> hw/rtl/vclp_div.sv
// Radix-2 restoring divider lane: 33-bit magnitude by 20-bit divisor,
// one quotient bit per step. Depends on vclp_pkg.
`default_nettype none
module vclp_div (
	input  wire logic        clk,
	input  wire logic        load,
	input  wire logic        step,
	input  wire logic [32:0] dividend,
	input  wire logic [19:0] divisor,
	output logic      [32:0] quo,
	output logic      [19:0] rem
);
	import vclp_pkg::*;

	logic [32:0] quo_q;
	logic [19:0] rem_q;
	logic [20:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[32]};
	assign fits  = trial >= {1'b0, divisor};

	// shift in one dividend bit, subtract when the divisor fits
	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (step) begin
			quo_q <= {quo_q[31:0], fits};
			rem_q <= fits ? 20'(trial - {1'b0, divisor}) : trial[19:0];
		end
	end

	assign quo = quo_q;
	assign rem = rem_q;

endmodule
`default_nettype wire

>>> hw/rtl/vclp_ctrl.sv
// Controller: clearing pass, request accept, divide sequencing, lookup
// and result strobe. Depends on vclp_pkg.
`default_nettype none
module vclp_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           opcode,
	input  wire logic           elevation_present,
	input  wire vclp_pkg::stat_t stat,
	output logic                busy,
	output logic                result_valid,
	output vclp_pkg::cmd_t      cmd
);
	import vclp_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_PREP  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_LOOK  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0] state_q, state_d;
	logic [5:0] cnt_q;
	logic       accept;

	assign busy         = state_q != ST_IDLE;
	assign accept       = start & ~busy;
	assign result_valid = state_q == ST_OUT;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (opcode == OP_LOAD) begin
						cmd.load_wr = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						state_d = elevation_present ? ST_PREP : ST_OUT;
					end
				end
			end
			ST_PREP: begin
				cmd.div_load = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) state_d = ST_LOOK;
			end
			ST_LOOK: begin
				cmd.lookup = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) cnt_q <= cnt_q + 6'd1;
			else cnt_q <= '0;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/vclp_dp.sv
// Datapath: offsets, three divider lanes, footprint test, voxel address
// and the voxel store. Depends on vclp_pkg and vclp_div.
`default_nettype none
module vclp_dp #(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_COLS   = 64,
	parameter int MAX_LAYERS = 32,
	parameter int CODE_WIDTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire vclp_pkg::cmd_t     cmd,
	input  wire vclp_pkg::cfg_t     cfg,
	input  wire logic signed [31:0] easting,
	input  wire logic signed [31:0] northing,
	input  wire logic signed [31:0] elevation,
	input  wire logic               elevation_present,
	input  wire logic [5:0]         load_column,
	input  wire logic [5:0]         load_row_from_bottom,
	input  wire logic [4:0]         load_layer,
	input  wire logic signed [15:0] load_code,
	output vclp_pkg::stat_t         stat,
	output logic signed [15:0]      rock_code,
	output logic [1:0]              lookup_status
);
	import vclp_pkg::*;

	localparam int DEPTH = MAX_LAYERS * MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);

	logic [CODE_WIDTH-1:0] mem [DEPTH];
	logic [CODE_WIDTH-1:0] rd_q;
	logic [AW-1:0]         clr_q;

	logic [6:0]  nr, nc;
	logic [5:0]  nl;
	logic [19:0] cs, lt;

	logic signed [32:0] dx_q, dy_q, dz_q;
	logic [1:0]  status_q;

	logic [32:0] qx, qy, qz;
	logic [19:0] rx, ry, rz;

	logic        we;
	logic [AW-1:0] wa, ra;
	logic [CODE_WIDTH-1:0] wd;
	logic [31:0] code32;

	logic [6:0]  load_row;
	logic        load_ok;
	logic        col_ok, row_ok, rbit;
	logic [33:0] rq;
	logic [6:0]  row_v, col_v;
	logic [5:0]  layer_v;
	logic signed [CODE_WIDTH-1:0] rd_s;
	logic [31:0] rd32;

	// effective counts and sizes
	always_comb begin
		nr = (cfg.row_count == 7'd0) ? 7'd1 :
		     ((32'(cfg.row_count) > MAX_ROWS) ? 7'(MAX_ROWS) : cfg.row_count);
		nc = (cfg.col_count == 7'd0) ? 7'd1 :
		     ((32'(cfg.col_count) > MAX_COLS) ? 7'(MAX_COLS) : cfg.col_count);
		nl = (cfg.layer_count == 6'd0) ? 6'd1 :
		     ((32'(cfg.layer_count) > MAX_LAYERS) ? 6'(MAX_LAYERS) : cfg.layer_count);
		cs = (cfg.cell_size == 20'd0) ? 20'd1 : cfg.cell_size;
		lt = (cfg.layer_thickness == 20'd0) ? 20'd1 : cfg.layer_thickness;
	end

	// capture offsets and the missing-elevation status
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dx_q     <= 33'(easting) - 33'(cfg.x_origin);
			dy_q     <= 33'(northing) - 33'(cfg.y_origin);
			dz_q     <= 33'(elevation) - 33'(cfg.z_origin);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= STATUS_FOUND;
		end else if (cmd.capture) begin
			status_q <= elevation_present ? STATUS_FOUND : STATUS_NO_ELEV;
		end else if (cmd.lookup) begin
			status_q <= (col_ok && row_ok) ? STATUS_FOUND : STATUS_OUTSIDE;
		end
	end

	// divide magnitudes
	vclp_div u_div_x (
		.clk(clk), .load(cmd.div_load), .step(cmd.div_step),
		.dividend(dx_q[32] ? 33'(-dx_q) : 33'(dx_q)), .divisor(cs),
		.quo(qx), .rem(rx)
	);
	vclp_div u_div_y (
		.clk(clk), .load(cmd.div_load), .step(cmd.div_step),
		.dividend(dy_q[32] ? 33'(-dy_q) : 33'(dy_q)), .divisor(cs),
		.quo(qy), .rem(ry)
	);
	vclp_div u_div_z (
		.clk(clk), .load(cmd.div_load), .step(cmd.div_step),
		.dividend(dz_q[32] ? 33'(-dz_q) : 33'(dz_q)), .divisor(lt),
		.quo(qz), .rem(rz)
	);

	// footprint test and voxel indices
	always_comb begin
		col_ok  = dx_q[32] ? (qx == 33'd0) : (qx <= 33'(nc) - 33'd1);
		rbit    = {ry, 1'b0} >= {1'b0, cs};
		rq      = {1'b0, qy} + 34'(rbit);
		row_ok  = dy_q[32] ? (rq == 34'd0) : (rq <= 34'(nr) - 34'd1);
		col_v   = dx_q[32] ? 7'd0 : qx[6:0];
		row_v   = dy_q[32] ? nr - 7'd1 : nr - 7'd1 - qy[6:0];
		layer_v = dz_q[32] ? 6'd0 :
		          ((qz > 33'(nl) - 33'd1) ? nl - 6'd1 : qz[5:0]);
		ra = AW'(((32'(layer_v) * MAX_ROWS) + 32'(row_v)) * MAX_COLS + 32'(col_v));
	end

	// load decode: flip the row, drop out-of-range indices
	always_comb begin
		load_row = nr - 7'd1 - {1'b0, load_row_from_bottom};
		load_ok  = ({1'b0, load_column} < nc) && ({1'b0, load_row_from_bottom} < nr) &&
		           ({1'b0, load_layer} < nl);
		code32   = {16'd0, load_code};
		if (cmd.clear_wr) begin
			we = 1'b1;
			wa = clr_q;
			wd = NO_DATA_32[CODE_WIDTH-1:0];
		end else begin
			we = cmd.load_wr & load_ok;
			wa = AW'(((32'(load_layer) * MAX_ROWS) + 32'(load_row)) * MAX_COLS
			         + 32'(load_column));
			wd = code32[CODE_WIDTH-1:0];
		end
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clear_wr) clr_q <= clr_q + 1'b1;
	end
	assign stat.clear_last = clr_q == AW'(DEPTH - 1);

	// voxel store
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (cmd.lookup) rd_q <= mem[ra];
	end

	// sign-extend the stored code, then keep 16 bits
	assign rd_s = rd_q;
	assign rd32 = 32'(rd_s);
	assign rock_code     = (status_q == STATUS_FOUND) ? rd32[15:0] : NO_DATA_CODE;
	assign lookup_status = status_q;

endmodule
`default_nettype wire

>>> hw/rtl/voxel_code_lookup_by_position_core.sv
// Voxel rock-code lookup by position. Load: written at the accepting edge, no result.
// Query: after accept, divider load, 33 divide steps on three parallel lanes,
// store read, then the result strobe; the strobe comes the cycle after accept with
// elevation missing. One request at a time: busy drops the cycle after the strobe,
// so a new query is taken only once the last one is through.
// Reset: registers to defaults, then a clearing pass over all MAX_LAYERS*MAX_ROWS*
// MAX_COLS voxels (131072 by default) with busy high.
`default_nettype none
module voxel_code_lookup_by_position_core #(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_COLS   = 64,
	parameter int MAX_LAYERS = 32,
	parameter int CODE_WIDTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               opcode,
	input  wire logic signed [31:0] easting,
	input  wire logic signed [31:0] northing,
	input  wire logic signed [31:0] elevation,
	input  wire logic               elevation_present,
	input  wire logic [5:0]         load_column,
	input  wire logic [5:0]         load_row_from_bottom,
	input  wire logic [4:0]         load_layer,
	input  wire logic signed [15:0] load_code,
	output logic                    result_valid,
	output logic signed [15:0]      rock_code,
	output logic [1:0]              lookup_status,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);
	import vclp_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	vclp_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	vclp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode),
		.elevation_present(elevation_present), .stat(stat), .busy(busy),
		.result_valid(result_valid), .cmd(cmd)
	);

	vclp_dp #(
		.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS),
		.MAX_LAYERS(MAX_LAYERS), .CODE_WIDTH(CODE_WIDTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cfg(cfg),
		.easting(easting), .northing(northing), .elevation(elevation),
		.elevation_present(elevation_present), .load_column(load_column),
		.load_row_from_bottom(load_row_from_bottom), .load_layer(load_layer),
		.load_code(load_code), .stat(stat), .rock_code(rock_code),
		.lookup_status(lookup_status)
	);

endmodule
`default_nettype wire

>>> hw/rtl/vclp_chk.sv
// Port-level checker for the voxel code lookup core, bound to the top level.
// Depends on vclp_pkg.
`default_nettype none
module vclp_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        opcode,
	input wire logic        result_valid,
	input wire logic [15:0] rock_code,
	input wire logic [1:0]  lookup_status
);
	import vclp_pkg::*;

	// result strobe lasts one cycle
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result strobe held");

	// results only while a request is in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result while idle");

	// a load gives no result
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_LOAD) |=> !result_valid)
		else $error("result after load");

	// failed lookups report no-data
	a_nodata: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && lookup_status != STATUS_FOUND) |->
		(rock_code == NO_DATA_CODE &&
		 (lookup_status == STATUS_NO_ELEV || lookup_status == STATUS_OUTSIDE)))
		else $error("bad no-data result");

endmodule

bind voxel_code_lookup_by_position_core vclp_chk u_vclp_chk (.*);
`default_nettype wire

>>> verif/voxel_code_lookup_by_position_core_tb.sv
// Testbench for the voxel code lookup core: loads voxels, queries positions
// and checks each result against a predictor kept in a small scoreboard class.
// Depends on vclp_pkg and voxel_code_lookup_by_position_core.
`timescale 1ns / 1ps
`default_nettype none
module voxel_code_lookup_by_position_core_tb;
	import vclp_pkg::*;

	localparam int ROWS = 64;
	localparam int COLS = 64;
	localparam int LAYERS = 32;
	localparam int DEPTH = ROWS * COLS * LAYERS;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic               op;
		logic signed [31:0] east;
		logic signed [31:0] north;
		logic signed [31:0] elev;
		logic               elev_ok;
		logic [5:0]         col;
		logic [5:0]         row_b;
		logic [4:0]         layer;
		logic signed [15:0] code;
	} request_t;

	typedef struct {
		logic signed [15:0] code;
		logic [1:0]         status;
	} answer_t;

	class lookup_scoreboard;
		logic signed [15:0] voxels [DEPTH];
		longint x0, y0, z0;
		longint cell_len, thick, rows, cols, layers;
		answer_t pending[$];
		int errors;

		function new();
			foreach (voxels[i]) voxels[i] = NO_DATA_CODE;
			x0 = 0; y0 = 0; z0 = 0;
			cell_len = 160; thick = 160; rows = 64; cols = 64; layers = 32;
			errors = 0;
		endfunction

		function longint eff(longint v, longint maxv);
			if (v == 0) return 1;
			if (v > maxv) return maxv;
			return v;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_X_ORIGIN:    x0 = longint'($signed(val));
				REG_Y_ORIGIN:    y0 = longint'($signed(val));
				REG_Z_ORIGIN:    z0 = longint'($signed(val));
				REG_CELL_SIZE:   cell_len = val[19:0];
				REG_LAYER_THICK: thick = val[19:0];
				REG_ROW_COUNT:   rows = val[6:0];
				REG_COL_COUNT:   cols = val[6:0];
				REG_LAYER_COUNT: layers = val[5:0];
				default: ;
			endcase
		endfunction

		// Predict the answer to an accepted request; loads only update the store
		function void note_request(request_t r);
			longint nr, nc, nl, cs, lt, dx, dy, dz, colp, mag, q, rowp, row, col, lay;
			answer_t a;
			nr = eff(rows, ROWS);
			nc = eff(cols, COLS);
			nl = eff(layers, LAYERS);
			if (r.op == OP_LOAD) begin
				if (r.col < nc && r.row_b < nr && r.layer < nl)
					voxels[(r.layer * ROWS + (nr - 1 - r.row_b)) * COLS + r.col] = r.code;
				return;
			end
			if (!r.elev_ok) begin
				a.code = NO_DATA_CODE;
				a.status = STATUS_NO_ELEV;
				pending = {pending, a};
				return;
			end
			cs = (cell_len == 0) ? 1 : cell_len;
			lt = (thick == 0) ? 1 : thick;
			dx = longint'(r.east) - x0;
			dy = longint'(r.north) - y0;
			dz = longint'(r.elev) - z0;
			colp = dx / cs;
			mag = (dy < 0) ? -dy : dy;
			q = (2 * mag + cs) / (2 * cs);
			rowp = (nr - 1) - ((dy < 0) ? -q : q);
			if (colp < 0 || colp > nc - 1 || rowp < 0 || rowp > nr - 1) begin
				a.code = NO_DATA_CODE;
				a.status = STATUS_OUTSIDE;
				pending = {pending, a};
				return;
			end
			col = (dx < 0) ? 0 : dx / cs;
			row = (dy < 0) ? nr - 1 : (nr - 1) - dy / cs;
			if (col > nc - 1) col = nc - 1;
			if (row < 0) row = 0;
			if (row > nr - 1) row = nr - 1;
			lay = (dz < 0) ? 0 : dz / lt;
			if (lay > nl - 1) lay = nl - 1;
			a.code = voxels[(lay * ROWS + row) * COLS + col];
			a.status = STATUS_FOUND;
			pending = {pending, a};
		endfunction

		function void check_result(logic signed [15:0] code, logic [1:0] status);
			answer_t a;
			if (pending.size() == 0) begin
				$error("result with no request waiting: rock_code %0d lookup_status %0d",
					code, status);
				errors++;
				return;
			end
			a = pending.pop_front();
			if (code !== a.code) begin
				$error("rock_code expected %0d actual %0d", a.code, code);
				errors++;
			end
			if (status !== a.status) begin
				$error("lookup_status expected %0d actual %0d", a.status, status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic opcode = 1'b0;
	logic signed [31:0] easting = '0;
	logic signed [31:0] northing = '0;
	logic signed [31:0] elevation = '0;
	logic elevation_present = 1'b0;
	logic [5:0] load_column = '0;
	logic [5:0] load_row_from_bottom = '0;
	logic [4:0] load_layer = '0;
	logic signed [15:0] load_code = '0;
	logic result_valid;
	logic signed [15:0] rock_code;
	logic [1:0] lookup_status;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	lookup_scoreboard sb = new();
	longint cycles = 0;
	int sender_idle_pct = 17;

	voxel_code_lookup_by_position_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.easting(easting), .northing(northing), .elevation(elevation),
		.elevation_present(elevation_present), .load_column(load_column),
		.load_row_from_bottom(load_row_from_bottom), .load_layer(load_layer),
		.load_code(load_code), .result_valid(result_valid), .rock_code(rock_code),
		.lookup_status(lookup_status), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Count cycles and stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Check every strobed result
	always @(posedge clk) begin
		if (arst_n && result_valid) sb.check_result(rock_code, lookup_status);
	end

	// Drive one request and hold it until accepted, then at random idle the sender cycle by cycle
	task automatic send(request_t r);
		opcode <= r.op;
		easting <= r.east;
		northing <= r.north;
		elevation <= r.elev;
		elevation_present <= r.elev_ok;
		load_column <= r.col;
		load_row_from_bottom <= r.row_b;
		load_layer <= r.layer;
		load_code <= r.code;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sb.note_request(r);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
	endtask

	task automatic load(int c, int rb, int l, int code);
		request_t r;
		r = '{OP_LOAD, $urandom, $urandom, $urandom, 1'($urandom_range(1)), 6'(c), 6'(rb),
			5'(l), 16'(code)};
		send(r);
	endtask

	task automatic query(longint e, longint n, longint z, bit ok);
		request_t r;
		r = '{OP_QUERY, 32'(e), 32'(n), 32'(z), ok, 6'($urandom), 6'($urandom),
			5'($urandom), 16'($urandom)};
		send(r);
	endtask

	// Wait until the block is quiet before touching registers
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0 || busy) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic configure(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] cs, logic [31:0] lt, logic [31:0] nr, logic [31:0] nc,
			logic [31:0] nl);
		settle();
		reg_write(REG_X_ORIGIN, x);
		reg_write(REG_Y_ORIGIN, y);
		reg_write(REG_Z_ORIGIN, z);
		reg_write(REG_CELL_SIZE, cs);
		reg_write(REG_LAYER_THICK, lt);
		reg_write(REG_ROW_COUNT, nr);
		reg_write(REG_COL_COUNT, nc);
		reg_write(REG_LAYER_COUNT, nl);
	endtask

	// Mostly well-aimed loads and queries inside the cube, some noise
	task automatic random_request();
		longint nr, nc, nl, cs, lt, c, rb, l;
		int pick;
		nr = sb.eff(sb.rows, ROWS);
		nc = sb.eff(sb.cols, COLS);
		nl = sb.eff(sb.layers, LAYERS);
		cs = (sb.cell_len == 0) ? 1 : sb.cell_len;
		lt = (sb.thick == 0) ? 1 : sb.thick;
		pick = $urandom_range(99);
		if (pick < 35) begin
			load($urandom_range(nc - 1), $urandom_range(nr - 1), $urandom_range(nl - 1),
				$urandom);
		end else if (pick < 42) begin
			load($urandom_range(63), $urandom_range(63), $urandom_range(31), $urandom);
		end else if (pick < 50) begin
			query($signed($urandom), $signed($urandom), $signed($urandom),
				1'($urandom_range(1)));
		end else if (pick < 55) begin
			query($signed($urandom), $signed($urandom), $signed($urandom), 1'b0);
		end else begin
			c = longint'($urandom_range(nc + 3)) - 2;
			rb = longint'($urandom_range(nr + 3)) - 2;
			l = longint'($urandom_range(nl + 3)) - 2;
			query(sb.x0 + c * cs + $urandom_range(cs - 1),
				sb.y0 + rb * cs + $urandom_range(cs - 1),
				sb.z0 + l * lt + $urandom_range(lt - 1), 1'b1);
		end
	endtask

	initial begin
		int n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// hold until the clearing pass finishes
		@(posedge clk);
		while (busy) @(posedge clk);

		configure(0, 0, 0, 160, 160, 64, 64, 32);

		// Directed: corner voxels, extreme codes, rounding and footprint edges
		load(0, 0, 0, -32768);
		load(63, 63, 31, 32767);
		load(10, 20, 5, 1234);
		query(5, 5, 5, 1);
		query(63 * 160 + 80, 63 * 160 + 10, 31 * 160 + 1, 1);
		query(10 * 160 + 159, 20 * 160, 5 * 160, 1);
		query(63 * 160, 63 * 160, 2147483647, 1);
		query(0, 0, -2147483648, 1);
		query(5, 5, 5, 0);
		query(-1, 5, 5, 1);
		query(-200, 5, 5, 1);
		query(64 * 160, 5, 5, 1);
		query(5, 63 * 160 + 80, 5, 1);
		query(5, 63 * 160 + 79, 5, 1);
		query(5, -80, 5, 1);
		query(5, -79, 5, 1);
		query(-2147483648, 2147483647, 0, 1);
		query(2147483647, -2147483648, 0, 1);
		load(64 - 1, 0, 31, -9999);
		query(63 * 160 + 1, 1, 31 * 160, 1);

		// Random phases over several register settings
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: configure(0, 0, 0, 160, 160, 64, 64, 32);
				1: configure(-1000, 5000, -300, 16, 8, 4, 5, 3);
				2: configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 20'hFFFFF, 1,
					1, 1, 1);
				3: configure(123456, -98765, 4000, 1, 20'hFFFFF, 127, 0, 63);
				4: configure(0, 0, 0, 0, 0, 2, 3, 0);
				default: configure(-50000, -50000, 1600, 37, 23, 8, 8, 4);
			endcase
			n = 230;
			for (int i = 0; i < n; i++) begin
				int k;
				k = p * n + i;
				sender_idle_pct = (k < 460) ? 17 : (k < 920) ? 56 : 0;
				random_request();
			end
		end

		settle();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
